// ===== design/llg_pkg.sv =====
//------------------------------------------------------------------------------
// List label generator package
// Shared widths, style codes, the sequencer control word and its program,
// and the constant tables for roman numerals and radix conversion.
//------------------------------------------------------------------------------
`default_nettype none

package llg_pkg;

  // Field widths.
  localparam int NUM_W   = 16;
  localparam int CHAR_W  = 8;
  localparam int STYLE_W = 3;

  // Label style codes; codes above the upper roman code fall back to decimal.
  localparam logic [STYLE_W-1:0] STYLE_DECIMAL     = 3'd0;
  localparam logic [STYLE_W-1:0] STYLE_LOWER_ALPHA = 3'd1;
  localparam logic [STYLE_W-1:0] STYLE_UPPER_ALPHA = 3'd2;
  localparam logic [STYLE_W-1:0] STYLE_LOWER_ROMAN = 3'd3;
  localparam logic [STYLE_W-1:0] STYLE_UPPER_ROMAN = 3'd4;

  // Character constants.
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_QUERY   = 8'h3F;
  localparam logic [CHAR_W-1:0] CASE_BIT     = 8'h20;

  // Reciprocal multipliers for division by the radix; exact over the 16-bit range.
  localparam logic [NUM_W-1:0] DEC_MULT    = 16'd52429;
  localparam int               DEC_SHIFT   = 19;
  localparam logic [NUM_W-1:0] ALPHA_MULT  = 16'd40330;
  localparam int               ALPHA_SHIFT = 20;
  localparam int               DIGIT_W     = 5;

  // Digit stack for the radix styles; five decimal digits at most.
  localparam int STACK_DEPTH = 8;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int SPI_W       = $clog2(STACK_DEPTH);

  // Roman numeral table, largest value last. Odd entries are subtractive pairs.
  localparam int ROMAN_COUNT = 13;
  localparam int IDX_W       = $clog2(ROMAN_COUNT);
  localparam int ROMAN_W     = 10;
  localparam logic [IDX_W-1:0] ROMAN_TOP = IDX_W'(ROMAN_COUNT - 1);
  localparam logic [NUM_W-1:0] ROMAN_LIMIT = 16'd5000;

  localparam logic [ROMAN_W-1:0] ROMAN_VALUE [ROMAN_COUNT] = '{
    10'd1, 10'd4, 10'd5, 10'd9, 10'd10, 10'd40, 10'd50,
    10'd90, 10'd100, 10'd400, 10'd500, 10'd900, 10'd1000
  };
  localparam logic [CHAR_W-1:0] ROMAN_FIRST [ROMAN_COUNT] = '{
    "i", "i", "v", "i", "x", "x", "l", "x", "c", "c", "d", "c", "m"
  };
  localparam logic [CHAR_W-1:0] ROMAN_SECOND [ROMAN_COUNT] = '{
    " ", "v", " ", "x", " ", "l", " ", "c", " ", "d", " ", "m", " "
  };

  // Datapath operations of one sequencer step.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_DIV,
    OP_PUSH,
    OP_POP,
    OP_ROM1,
    OP_ROM2,
    OP_QMARK,
    OP_DONE
  } op_t;

  // Jump conditions of one sequencer step.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_ZERO,
    C_ROMAN,
    C_Q_NZ,
    C_SP_MORE,
    C_BIG,
    C_R_AGAIN,
    C_HIT,
    C_REM_NZ
  } cond_t;

  localparam int PROG_LEN = 14;
  localparam int PC_W     = $clog2(PROG_LEN);

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Program addresses.
  localparam logic [PC_W-1:0] A_DIV   = 4'd2;
  localparam logic [PC_W-1:0] A_POP   = 4'd4;
  localparam logic [PC_W-1:0] A_ROMAN = 4'd6;
  localparam logic [PC_W-1:0] A_RSTEP = 4'd7;
  localparam logic [PC_W-1:0] A_RPAIR = 4'd10;
  localparam logic [PC_W-1:0] A_QMARK = 4'd12;
  localparam logic [PC_W-1:0] A_END   = 4'd13;

  // Control store.
  localparam ctrl_t PROGRAM [PROG_LEN] = '{
    '{OP_NOP,   C_ZERO,    A_END},    // nothing to label
    '{OP_NOP,   C_ROMAN,   A_ROMAN},
    '{OP_DIV,   C_NEVER,   A_END},    // quotient by reciprocal
    '{OP_PUSH,  C_Q_NZ,    A_DIV},    // stack the digit, loop on quotient
    '{OP_POP,   C_SP_MORE, A_POP},    // send digits most significant first
    '{OP_NOP,   C_ALWAYS,  A_END},
    '{OP_NOP,   C_BIG,     A_QMARK},
    '{OP_ROM1,  C_R_AGAIN, A_RSTEP},  // greedy table walk
    '{OP_NOP,   C_HIT,     A_RPAIR},
    '{OP_NOP,   C_ALWAYS,  A_END},
    '{OP_ROM2,  C_REM_NZ,  A_RSTEP},  // second symbol of a pair
    '{OP_NOP,   C_ALWAYS,  A_END},
    '{OP_QMARK, C_ALWAYS,  A_END},
    '{OP_DONE,  C_NEVER,   A_END}
  };

endpackage

`default_nettype wire

// ===== design/list_label_generator.sv =====
//------------------------------------------------------------------------------
// List label generator
// Turns a one-based list item number into its label characters.
//------------------------------------------------------------------------------
// The input channel (in_valid, in_stall, list_number) takes one item number.
// The output channel (out_valid, out_stall, label_char, last_char) returns the
// label one character per word, most significant first, with last_char set on
// the final word. A number of zero gives no words at all. label_style is
// written through cfg_write and cfg_data; the user must write it only while
// the block is idle, since the block itself does not enforce it. One item is
// worked at a time by a small microcoded sequencer; in_stall is high from
// acceptance until the sequencer has finished, after the final word has
// entered the output register. Decimal and alpha labels take two setup steps,
// two steps per character on the reciprocal multiplier and digit stack, one
// per character to send and two to finish; their first word is sent once all
// digits are stacked. Roman labels take three setup steps, one per table
// entry passed, one per character, one more per subtractive pair and two or
// three to finish. A zero jumps straight to the finishing step, and the
// question mark is sent from a step of its own. A waiting next number is
// taken as soon as the block is idle.
// Reset clears the style to decimal, empties the output register and returns
// the sequencer to idle. When the receiver stalls, the output word holds and
// the sequencer waits at its next sending step for every stalled cycle.
//------------------------------------------------------------------------------
`default_nettype none

module list_label_generator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [llg_pkg::STYLE_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [llg_pkg::NUM_W-1:0]    list_number,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [llg_pkg::CHAR_W-1:0]   label_char,
  output logic                         last_char
);
  import llg_pkg::*;

  logic                 busy;
  logic [PC_W-1:0]      pc;
  logic [STYLE_W-1:0]   label_style;
  logic [NUM_W-1:0]     num;
  logic [NUM_W-1:0]     quo;
  logic [IDX_W-1:0]     idx;
  logic [SP_W-1:0]      sp;
  logic [CHAR_W-1:0]    stack [STACK_DEPTH];

  ctrl_t                cw;
  logic                 is_alpha;
  logic                 is_roman;
  logic                 upper;
  logic [NUM_W-1:0]     dividend;
  logic [2*NUM_W-1:0]   product;
  logic [2*NUM_W-1:0]   shifted;
  logic [NUM_W-1:0]     quo_next;
  logic [NUM_W-1:0]     quo_times;
  logic [NUM_W-1:0]     digit_diff;
  logic [CHAR_W-1:0]    digit_base;
  logic [CHAR_W-1:0]    push_char;
  logic [NUM_W:0]       rom_diff;
  logic [NUM_W-1:0]     rom_rem;
  logic                 rom_hit;
  logic                 rom_pair;
  logic                 rom_end;
  logic [CHAR_W-1:0]    rom_char1;
  logic [CHAR_W-1:0]    rom_char2;
  logic                 big;
  logic [SPI_W-1:0]     top;
  logic                 slot_free;
  logic                 emit;
  logic [CHAR_W-1:0]    emit_char;
  logic                 emit_last;
  logic                 hold;
  logic                 step;
  logic                 jump;
  logic                 accept;

  // Current control word and style decode.
  assign cw       = PROGRAM[pc];
  assign is_alpha = (label_style inside {STYLE_LOWER_ALPHA, STYLE_UPPER_ALPHA});
  assign is_roman = (label_style inside {STYLE_LOWER_ROMAN, STYLE_UPPER_ROMAN});
  assign upper    = (label_style inside {STYLE_UPPER_ALPHA, STYLE_UPPER_ROMAN});

  // Radix path: alpha is bijective, so it divides one less than the number.
  assign dividend = is_alpha ? num - NUM_W'(1) : num;
  assign product  = dividend * (is_alpha ? ALPHA_MULT : DEC_MULT);
  assign shifted  = is_alpha ? (product >> ALPHA_SHIFT) : (product >> DEC_SHIFT);
  assign quo_next = shifted[NUM_W-1:0];

  // Remainder from the registered quotient, times 26 or times 10 by shifts.
  assign quo_times = is_alpha ? NUM_W'((quo << 4) + (quo << 3) + (quo << 1))
                              : NUM_W'((quo << 3) + (quo << 1));
  assign digit_diff = dividend - quo_times;
  assign digit_base = is_alpha ? (upper ? CHAR_UPPER_A : CHAR_LOWER_A) : CHAR_ZERO;
  assign push_char  = digit_base + CHAR_W'(digit_diff[DIGIT_W-1:0]);

  // Roman path: compare against the current table entry.
  assign rom_diff  = {1'b0, num} - {(NUM_W + 1 - ROMAN_W)'(0), ROMAN_VALUE[idx]};
  assign rom_hit   = !rom_diff[NUM_W];
  assign rom_rem   = rom_diff[NUM_W-1:0];
  assign rom_pair  = idx[0];
  assign rom_end   = (rom_rem == '0);
  assign rom_char1 = upper ? (ROMAN_FIRST[idx] & ~CASE_BIT) : ROMAN_FIRST[idx];
  assign rom_char2 = upper ? (ROMAN_SECOND[idx] & ~CASE_BIT) : ROMAN_SECOND[idx];
  assign big       = (num >= ROMAN_LIMIT);

  assign top = SPI_W'(sp - SP_W'(1));

  // Word to send in this step, if any.
  always_comb begin
    emit      = 1'b0;
    emit_char = stack[top];
    emit_last = 1'b0;
    case (cw.op)
      OP_POP: begin
        emit      = 1'b1;
        emit_char = stack[top];
        emit_last = (sp == SP_W'(1));
      end
      OP_ROM1: begin
        emit      = rom_hit;
        emit_char = rom_char1;
        emit_last = !rom_pair && rom_end;
      end
      OP_ROM2: begin
        emit      = 1'b1;
        emit_char = rom_char2;
        emit_last = rom_end;
      end
      OP_QMARK: begin
        emit      = 1'b1;
        emit_char = CHAR_QUERY;
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // A sending step waits until the output register is free.
  assign slot_free = !out_valid || !out_stall;
  assign hold      = emit && !slot_free;
  assign step      = busy && !hold;
  assign accept    = in_valid && !busy;
  assign in_stall  = busy;

  // Jump condition of the current step.
  always_comb begin
    case (cw.cond)
      C_NEVER:   jump = 1'b0;
      C_ALWAYS:  jump = 1'b1;
      C_ZERO:    jump = (num == '0);
      C_ROMAN:   jump = is_roman;
      C_Q_NZ:    jump = (quo != '0);
      C_SP_MORE: jump = (sp > SP_W'(1));
      C_BIG:     jump = big;
      C_R_AGAIN: jump = !(rom_hit && (rom_pair || rom_end));
      C_HIT:     jump = rom_hit;
      C_REM_NZ:  jump = !rom_end;
      default:   jump = 1'b0;
    endcase
  end

  // Sequencer, style register and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      pc          <= '0;
      label_style <= STYLE_DECIMAL;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        label_style <= cfg_data;
      end
      if (emit && step) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
        pc   <= '0;
      end else if (step) begin
        if (cw.op == OP_DONE) begin
          busy <= 1'b0;
          pc   <= '0;
        end else if (jump) begin
          pc <= cw.target;
        end else begin
          pc <= PC_W'(pc + PC_W'(1));
        end
      end
    end
  end

  // Stack pointer and table index follow the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      sp  <= '0;
      idx <= ROMAN_TOP;
    end else if (accept) begin
      sp  <= '0;
      idx <= ROMAN_TOP;
    end else if (step) begin
      case (cw.op)
        OP_PUSH: sp <= SP_W'(sp + SP_W'(1));
        OP_POP:  sp <= SP_W'(sp - SP_W'(1));
        OP_ROM1: begin
          if (!rom_hit && idx != '0) begin
            idx <= IDX_W'(idx - IDX_W'(1));
          end
        end
        default: begin
          sp <= sp;
        end
      endcase
    end
  end

  // Working number, quotient and digit stack.
  always_ff @(posedge clk) begin
    if (accept) begin
      num <= list_number;
    end else if (step) begin
      case (cw.op)
        OP_DIV: quo <= quo_next;
        OP_PUSH: begin
          stack[sp[SPI_W-1:0]] <= push_char;
          num                  <= quo;
        end
        OP_ROM1: begin
          if (rom_hit && !rom_pair) begin
            num <= rom_rem;
          end
        end
        OP_ROM2: num <= rom_rem;
        default: begin
          num <= num;
        end
      endcase
    end
  end

  // Output word.
  always_ff @(posedge clk) begin
    if (emit && step) begin
      label_char <= emit_char;
      last_char  <= emit_last;
    end
  end

endmodule

`default_nettype wire

// ===== design/llg_checker.sv =====
//------------------------------------------------------------------------------
// List label generator checker
// Port-level assertions on the label generator, attached by a bind.
//------------------------------------------------------------------------------
`default_nettype none

module llg_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [llg_pkg::CHAR_W-1:0]   label_char,
  input  logic                         last_char
);

  // An accepted number closes the input until its label is done.
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall
  ) else $error("input open right after an accepted number");

  // A word that is not the last one means the label is still in progress.
  a_open_label_stalls: assert property (
    @(posedge clk) disable iff (rst)
    out_valid && !last_char |-> in_stall
  ) else $error("input open in the middle of a label");

  // A stalled output word holds.
  a_out_hold: assert property (
    @(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(label_char) && $stable(last_char)
  ) else $error("stalled output word changed");

  // Reset leaves no word on the output and the input open.
  a_reset_empty: assert property (
    @(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid && !in_stall
  ) else $error("output or busy not cleared by reset");

endmodule

bind list_label_generator llg_checker u_llg_checker (.*);

`default_nettype wire

// ===== tb/sv/list_label_generator_tb.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// List label generator testbench
// Sends list item numbers under every label style and compares each label
// word with a label computed here. Both channels idle and stall at random.
//------------------------------------------------------------------------------

module list_label_generator_tb;
  import llg_pkg::*;

  // Style codes that the block treats as decimal.
  localparam logic [STYLE_W-1:0] STYLE_SPARE_5 = 3'd5;
  localparam logic [STYLE_W-1:0] STYLE_SPARE_6 = 3'd6;
  localparam logic [STYLE_W-1:0] STYLE_SPARE_7 = 3'd7;

  localparam int          MAX_LABEL_LEN = 16;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          ROMAN_CEILING = 5000;
  localparam logic [7:0]  NO_SYMBOL     = 8'h00;
  localparam logic [7:0]  LOWER_CASE    = 8'h20;

  // Greedy roman table, smallest value first. Odd entries are subtractive pairs.
  localparam int NUMERAL_VALUE [13] = '{
    1, 4, 5, 9, 10, 40, 50, 90, 100, 400, 500, 900, 1000
  };
  localparam logic [7:0] NUMERAL_HEAD [13] = '{
    "I", "I", "V", "I", "X", "X", "L", "X", "C", "C", "D", "C", "M"
  };
  localparam logic [7:0] NUMERAL_TAIL [13] = '{
    NO_SYMBOL, "V", NO_SYMBOL, "X", NO_SYMBOL, "L", NO_SYMBOL, "C",
    NO_SYMBOL, "D", NO_SYMBOL, "M", NO_SYMBOL
  };

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } label_word_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_write   = 1'b0;
  logic [STYLE_W-1:0] cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [NUM_W-1:0]   list_number = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [CHAR_W-1:0]  label_char;
  logic               last_char;

  logic [STYLE_W-1:0] style_shadow = STYLE_DECIMAL;
  label_word_t        expected_chars [$];
  label_word_t        want_word;
  bit                 back_to_back = 1'b0;
  int                 error_count  = 0;

  list_label_generator i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .list_number (list_number),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .label_char  (label_char),
    .last_char   (last_char)
  );

  // Free-running clock, 10 ns period.
  always #5 clk = ~clk;

  // Works out the label of one item and queues its words.
  function automatic void predict_label(input logic [NUM_W-1:0] n);
    logic [7:0] chars [MAX_LABEL_LEN];
    logic [7:0] digits [8];
    logic [7:0] case_ofs;
    int len, k, rest, q, i, j, cnt;
    label_word_t w;
    len  = 0;
    k    = 0;
    rest = n;
    if (n == 0) return;  // Not in the list: no label at all.
    case (style_shadow)
      STYLE_LOWER_ALPHA, STYLE_UPPER_ALPHA: begin
        // Bijective base 26: a..z, then aa, ab and so on.
        while (rest > 0 && k < 8) begin
          rest = rest - 1;
          digits[k] = ((style_shadow == STYLE_LOWER_ALPHA) ? "a" : "A") + 8'(rest % 26);
          k++;
          rest = rest / 26;
        end
        while (k > 0) begin
          k--;
          chars[len] = digits[k];
          len++;
        end
      end
      STYLE_LOWER_ROMAN, STYLE_UPPER_ROMAN: begin
        case_ofs = (style_shadow == STYLE_LOWER_ROMAN) ? LOWER_CASE : 8'h00;
        if (rest >= ROMAN_CEILING) begin
          // Too large for a numeral: a single question mark.
          chars[0] = "?";
          len = 1;
        end else begin
          for (i = 12; i >= 0; i--) begin
            q = rest / NUMERAL_VALUE[i];
            if (q > 0) begin
              cnt = (i % 4 == 0) ? q : ((i % 4 == 2) ? 1 : 2);
              for (j = 0; j < cnt && len < MAX_LABEL_LEN; j++) begin
                if (i % 2 == 1 && j == 1) chars[len] = NUMERAL_TAIL[i] | case_ofs;
                else chars[len] = NUMERAL_HEAD[i] | case_ofs;
                len++;
              end
            end
            rest = rest % NUMERAL_VALUE[i];
          end
        end
      end
      default: begin
        // Decimal, also for the spare style codes.
        do begin
          digits[k] = "0" + 8'(rest % 10);
          k++;
          rest = rest / 10;
        end while (rest > 0 && k < 8);
        while (k > 0) begin
          k--;
          chars[len] = digits[k];
          len++;
        end
      end
    endcase
    for (k = 0; k < len; k++) begin
      w.ch   = chars[k];
      w.last = (k == len - 1);
      expected_chars.push_back(w);
    end
  endfunction

  // Draws an item number, mostly in the range that matters for the style.
  function automatic logic [NUM_W-1:0] pick_number(input bit roman);
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel < 7) return NUM_W'($urandom_range(1, 100));
    if (roman) begin
      if (sel < 9) return NUM_W'($urandom_range(4990, 65535));
      return NUM_W'($urandom_range(1, 4999));
    end
    if (sel < 10) return NUM_W'($urandom_range(18200, 18300));
    return NUM_W'($urandom());
  endfunction

  // Sends one item number and queues its label once the block takes it.
  task automatic send_number(input logic [NUM_W-1:0] n);
    int gap;
    gap = back_to_back ? 0 : int'($urandom_range(0, 10));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    list_number <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_label(n);
  endtask

  // Waits for the block to go idle, then writes the style register.
  task automatic write_style(input logic [STYLE_W-1:0] style);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= style;
    @(posedge clk);
    cfg_write    <= 1'b0;
    style_shadow = style;
  endtask

  task automatic test_decimal_edges();
    send_number(16'd0);
    send_number(16'd1);
    send_number(16'd9);
    send_number(16'd10);
    send_number(16'd65535);
  endtask

  task automatic test_alpha_edges();
    write_style(STYLE_LOWER_ALPHA);
    send_number(16'd1);
    send_number(16'd26);
    send_number(16'd27);
    send_number(16'd702);
    send_number(16'd703);
    send_number(16'd65535);
    write_style(STYLE_UPPER_ALPHA);
    send_number(16'd1);
    send_number(16'd18278);
    send_number(16'd18279);
  endtask

  task automatic test_roman_edges();
    write_style(STYLE_LOWER_ROMAN);
    send_number(16'd4888);
    send_number(16'd3999);
    send_number(16'd4);
    send_number(16'd9);
    send_number(16'd4999);
    send_number(16'd5000);
    write_style(STYLE_UPPER_ROMAN);
    send_number(16'd1);
    send_number(16'd4000);
    send_number(16'd65535);
  endtask

  task automatic test_spare_styles();
    write_style(STYLE_SPARE_7);
    send_number(16'd42);
    send_number(16'd0);
  endtask

  task automatic test_random_styles();
    logic [STYLE_W-1:0] order [8];
    int p, m;
    bit roman;
    order = '{STYLE_UPPER_ROMAN, STYLE_LOWER_ALPHA, STYLE_LOWER_ROMAN, STYLE_DECIMAL,
              STYLE_UPPER_ALPHA, STYLE_SPARE_5, STYLE_SPARE_6, STYLE_SPARE_7};
    for (p = 0; p < 8; p++) begin
      write_style(order[p]);
      roman = (order[p] == STYLE_LOWER_ROMAN) || (order[p] == STYLE_UPPER_ROMAN);
      for (m = 0; m < 40; m++) send_number(pick_number(roman));
    end
  endtask

  // Full rate on both sides, upper roman labels and then decimal ones.
  task automatic test_back_to_back();
    int m;
    write_style(STYLE_UPPER_ROMAN);
    back_to_back = 1'b1;
    for (m = 0; m < 30; m++) send_number(pick_number(1'b1));
    write_style(STYLE_DECIMAL);
    for (m = 0; m < 10; m++) send_number(pick_number(1'b0));
    back_to_back = 1'b0;
  endtask

  // Receiver: holds off a random number of cycles before each word.
  initial begin : receiver
    int hold;
    forever begin
      hold = back_to_back ? 0 : int'($urandom_range(0, 10));
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Compare each accepted word with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected word: label_char %h last_char %b", label_char, last_char);
        error_count++;
      end else begin
        want_word = expected_chars.pop_front();
        if (label_char !== want_word.ch) begin
          $error("label_char mismatch: expected %h, actual %h", want_word.ch, label_char);
          error_count++;
        end
        if (last_char !== want_word.last) begin
          $error("last_char mismatch: expected %b, actual %b", want_word.last, last_char);
          error_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_decimal_edges();
    test_alpha_edges();
    test_roman_edges();
    test_spare_styles();
    test_random_styles();
    test_back_to_back();
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/llg_pkg.sv
design/list_label_generator.sv
design/llg_checker.sv
tb/sv/list_label_generator_tb.sv
